>>> design/psg_pkg.sv
`default_nettype none

package psg_pkg;

   localparam int VALUE_W   = 16;
   localparam int STEP_W    = 8;
   localparam int PERIOD_W  = 30;
   localparam int MODE_W    = 3;
   localparam int OP_W      = 2;
   localparam int CSR_IDX_W = 3;

   // 1e9 divided by the rate in mHz gives the sweep cycle in us
   localparam logic [PERIOD_W-1:0] NS_PER_SEC_MILLI = 30'd1000000000;

   // sweep modes
   localparam logic [MODE_W-1:0] MODE_OFF      = 3'd0;
   localparam logic [MODE_W-1:0] MODE_UP       = 3'd1;
   localparam logic [MODE_W-1:0] MODE_DN       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_UP_RESET = 3'd3;
   localparam logic [MODE_W-1:0] MODE_DN_RESET = 3'd4;
   localparam logic [MODE_W-1:0] MODE_UP_DOWN  = 3'd5;
   localparam logic [MODE_W-1:0] MODE_DN_UP    = 3'd6;

   // request opcodes
   localparam logic [OP_W-1:0] OP_TICK      = 2'd0;
   localparam logic [OP_W-1:0] OP_RECOMPUTE = 2'd1;
   localparam logic [OP_W-1:0] OP_SET       = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] REG_SWEEP_MODE    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_NOTIFY_ENABLE = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MIN     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_RANGE_MAX     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_CYCLE_RATE    = 3'd4;

   typedef struct packed {
      logic [OP_W-1:0]    opcode;
      logic [VALUE_W-1:0] new_value;
   } psg_req_type;

   typedef struct packed {
      logic [VALUE_W-1:0] current_value;
      logic               value_updated;
      logic               at_end;
      logic               notify;
   } psg_rsp_type;

   typedef struct packed {
      logic                start;
      logic [PERIOD_W-1:0] dividend;
      logic [VALUE_W-1:0]  divisor;
   } div_req_type;

   typedef struct packed {
      logic                busy;
      logic                done;
      logic [PERIOD_W-1:0] quotient;
   } div_rsp_type;

endpackage

`default_nettype wire

>>> design/psg_div.sv
`default_nettype none

// Restoring divider, one quotient bit per cycle.
module psg_div import psg_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire div_req_type div_req,
   output div_rsp_type      div_rsp
);

   localparam int CNT_W = $clog2(PERIOD_W);
   localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PERIOD_W - 1);

   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [VALUE_W-1:0]  rem_ff, rem_in;
   logic [PERIOD_W-1:0] quo_ff, quo_in;
   logic [VALUE_W-1:0]  dvs_ff, dvs_in;

   logic [VALUE_W:0] trial;
   logic [VALUE_W:0] diff;
   logic             fits;

   assign trial = {rem_ff, quo_ff[PERIOD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = LAST_CNT;
         rem_in  = '0;
         quo_in  = div_req.dividend;
         dvs_in  = div_req.divisor;
      end else if (busy_ff) begin
         rem_in = fits ? diff[VALUE_W-1:0] : trial[VALUE_W-1:0];
         quo_in = {quo_ff[PERIOD_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign div_rsp.busy     = busy_ff;
   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

`default_nettype wire

>>> design/parameter_sweep_generator.sv
// Tick, set and unused opcodes: pass EXEC, then OUT registers the response; a new request is taken only in IDLE.
// Recompute: one shared divider computes the period, then span / step for each step size
// tried in the search, then the final ratio; when disabled, it goes straight from EXEC to OUT.
// Synchronous active-high reset: registers to their defaults (range_max 0xFFFF, sweep active),
// countdown, step and value to zero, no beat pending. No clearing pass.
`default_nettype none

module parameter_sweep_generator import psg_pkg::*; #(
   parameter int STEP_LIMIT = 100
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire psg_req_type          req_data,
   // response channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output psg_rsp_type               rsp_data,
   // register write port
   input  wire logic                 csr_we,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [VALUE_W-1:0]   csr_wdata
);

   // step search counter holds 1..STEP_LIMIT, or 0 for a zero range
   localparam int CNT_W = $clog2(STEP_LIMIT + 1);
   localparam logic [CNT_W-1:0] STEP_END = CNT_W'(STEP_LIMIT);

   // sequencer states
   localparam logic [2:0] ST_IDLE   = 3'd0;
   localparam logic [2:0] ST_EXEC   = 3'd1;  // tick / set / start recompute
   localparam logic [2:0] ST_PERIOD = 3'd2;  // 1e9 / rate
   localparam logic [2:0] ST_SEARCH = 3'd3;  // launch span / step
   localparam logic [2:0] ST_DELTA  = 3'd4;  // check delta against period
   localparam logic [2:0] ST_RATIO  = 3'd5;  // period / delta
   localparam logic [2:0] ST_FINISH = 3'd6;  // apply direction, store step
   localparam logic [2:0] ST_OUT    = 3'd7;  // hand beat to output register

   logic [2:0] state_ff, state_in;

   // configuration
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic               notify_en_ff, notify_en_in;
   logic [VALUE_W-1:0] min_ff, min_in;
   logic [VALUE_W-1:0] max_ff, max_in;
   logic [VALUE_W-1:0] rate_ff, rate_in;

   // sweep state
   logic [VALUE_W-1:0]  value_ff, value_in;
   logic [STEP_W-1:0]   step_ff, step_in;       // two's complement
   logic [PERIOD_W-1:0] upd_period_ff, upd_period_in;
   logic [PERIOD_W-1:0] ticks_ff, ticks_in;
   logic                active_ff, active_in;

   // per-beat working registers
   logic [OP_W-1:0]     op_ff, op_in;
   logic [VALUE_W-1:0]  nv_ff, nv_in;
   logic [STEP_W-1:0]   prev_step_ff, prev_step_in;
   logic [PERIOD_W-1:0] period_ff, period_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic                upd_ff, upd_in;
   logic                end_ff, end_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   psg_rsp_type rsp_data_ff, rsp_data_in;

   div_req_type div_req;
   div_rsp_type div_rsp;

   psg_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // ---------------------------------------------------------------------------------------
   // Datapath terms
   // ---------------------------------------------------------------------------------------
   logic                live;
   logic                rc_go;
   logic [VALUE_W-1:0]  span;
   logic [PERIOD_W-1:0] ticks_dec;
   logic                fire;
   logic                step_neg;
   logic                step_pos;
   logic [VALUE_W-1:0]  moved;
   logic                hit_end;
   logic [VALUE_W-1:0]  clamped;
   logic [VALUE_W-1:0]  delta;
   logic                prev_pos;
   logic                flip_dir;
   logic [STEP_W-1:0]   step_mag_new;
   logic [STEP_W-1:0]   step_mag;

   assign live  = (mode_ff >= MODE_UP) && (mode_ff <= MODE_DN_UP) && active_ff;
   assign rc_go = live && (rate_ff != '0);
   // inverted range counts as zero span
   assign span  = (max_ff > min_ff) ? (max_ff - min_ff) : '0;

   // countdown never wraps below zero
   assign ticks_dec = (ticks_ff != '0) ? (ticks_ff - 1'b1) : ticks_ff;
   assign fire      = (ticks_dec == '0) && live && (rate_ff != '0) && (step_ff != '0);

   assign step_neg = step_ff[STEP_W-1];
   assign step_pos = !step_neg && (step_ff != '0);
   assign moved    = value_ff + {{(VALUE_W-STEP_W){step_ff[STEP_W-1]}}, step_ff};
   // end of range, or wrap past 16 bits in the direction of travel
   assign hit_end  = (moved <= min_ff) || (moved >= max_ff) ||
                     (step_neg && (moved > value_ff)) ||
                     (step_pos && (moved < value_ff));

   // set: top bound checked first, so an inverted range yields max for large values
   assign clamped = (nv_ff > max_ff) ? max_ff :
                    (nv_ff < min_ff) ? min_ff : nv_ff;

   assign delta = div_rsp.quotient[VALUE_W-1:0];

   // negative step for downward modes, for down-up after a positive step, for up-down after a negative one
   assign prev_pos = !prev_step_ff[STEP_W-1] && (prev_step_ff != '0);
   assign flip_dir = (mode_ff == MODE_DN_RESET) || (mode_ff == MODE_DN) ||
                     ((mode_ff == MODE_DN_UP) && prev_pos) ||
                     ((mode_ff == MODE_UP_DOWN) && prev_step_ff[STEP_W-1]);
   assign step_mag_new = {{(STEP_W-CNT_W){1'b0}}, cnt_ff};

   assign step_mag = step_ff[STEP_W-1] ? (STEP_W'(0) - step_ff) : step_ff;

   // ---------------------------------------------------------------------------------------
   // Divider launches: period, then span/step for each step tried, then period/delta
   // ---------------------------------------------------------------------------------------
   always_comb begin
      div_req = '0;
      unique case (state_ff)
         ST_EXEC: begin
            div_req.start    = (op_ff == OP_RECOMPUTE) && rc_go;
            div_req.dividend = NS_PER_SEC_MILLI;
            div_req.divisor  = rate_ff;
         end
         ST_SEARCH: begin
            div_req.start    = cnt_ff < STEP_END;
            div_req.dividend = {{(PERIOD_W-VALUE_W){1'b0}}, span};
            div_req.divisor  = {{(VALUE_W-CNT_W){1'b0}}, cnt_ff};
         end
         ST_DELTA: begin
            div_req.start    = div_rsp.done && (div_rsp.quotient != '0) &&
                               (period_ff >= div_rsp.quotient);
            div_req.dividend = period_ff;
            div_req.divisor  = delta;
         end
         default: begin
            div_req = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------------------------
   // Sequencer and state update
   // ---------------------------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      notify_en_in  = notify_en_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      rate_in       = rate_ff;
      value_in      = value_ff;
      step_in       = step_ff;
      upd_period_in = upd_period_ff;
      ticks_in      = ticks_ff;
      active_in     = active_ff;
      op_in         = op_ff;
      nv_in         = nv_ff;
      prev_step_in  = prev_step_ff;
      period_in     = period_ff;
      cnt_in        = cnt_ff;
      upd_in        = upd_ff;
      end_in        = end_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               op_in    = req_data.opcode;
               nv_in    = req_data.new_value;
               state_in = ST_EXEC;
            end
         end

         ST_EXEC: begin
            upd_in   = 1'b0;
            end_in   = 1'b0;
            state_in = ST_OUT;
            unique case (op_ff)
               OP_TICK: begin
                  ticks_in = ticks_dec;
                  if (fire) begin
                     ticks_in = upd_period_ff;
                     upd_in   = 1'b1;
                     end_in   = hit_end;
                     value_in = moved;
                     if (hit_end) begin
                        unique case (mode_ff)
                           MODE_UP_DOWN, MODE_DN_UP: begin
                              value_in = step_neg ? min_ff : max_ff;
                              step_in  = STEP_W'(0) - step_ff;
                           end
                           MODE_UP_RESET: begin
                              value_in = min_ff;
                           end
                           MODE_DN_RESET: begin
                              value_in = max_ff;
                           end
                           MODE_UP: begin
                              value_in  = max_ff;
                              active_in = 1'b0;
                           end
                           default: begin
                              // one-shot downward
                              value_in  = min_ff;
                              active_in = 1'b0;
                           end
                        endcase
                     end
                  end
               end
               OP_RECOMPUTE: begin
                  if (rc_go) begin
                     prev_step_in = step_ff;
                     cnt_in       = CNT_W'(1);
                     state_in     = ST_PERIOD;
                  end
               end
               OP_SET: begin
                  value_in = clamped;
               end
               default: begin
                  // unused opcode: report only
               end
            endcase
         end

         ST_PERIOD: begin
            if (div_rsp.done) begin
               period_in = div_rsp.quotient;
               state_in  = ST_SEARCH;
            end
         end

         ST_SEARCH: begin
            // search exhausted: keep the limit, period untouched
            state_in = (cnt_ff < STEP_END) ? ST_DELTA : ST_FINISH;
         end

         ST_DELTA: begin
            if (div_rsp.done) begin
               if (div_rsp.quotient == '0) begin
                  cnt_in   = '0;
                  state_in = ST_FINISH;
               end else if (period_ff >= div_rsp.quotient) begin
                  state_in = ST_RATIO;
               end else begin
                  cnt_in   = cnt_ff + 1'b1;
                  state_in = ST_SEARCH;
               end
            end
         end

         ST_RATIO: begin
            if (div_rsp.done) begin
               upd_period_in = div_rsp.quotient;
               state_in      = ST_FINISH;
            end
         end

         ST_FINISH: begin
            step_in  = flip_dir ? (STEP_W'(0) - step_mag_new) : step_mag_new;
            state_in = ST_OUT;
         end

         ST_OUT: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in                = 1'b1;
               rsp_data_in.current_value   = value_ff;
               rsp_data_in.value_updated   = upd_ff;
               rsp_data_in.at_end          = end_ff;
               rsp_data_in.notify          = end_ff && notify_en_ff;
               state_in                    = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // register writes must arrive only while idle; the block itself does not enforce this
      if (csr_we) begin
         unique case (csr_index)
            REG_SWEEP_MODE: begin
               mode_in   = csr_wdata[MODE_W-1:0];
               active_in = 1'b1;
            end
            REG_NOTIFY_ENABLE: notify_en_in = csr_wdata[0];
            REG_RANGE_MIN:     min_in       = csr_wdata;
            REG_RANGE_MAX:     max_in       = csr_wdata;
            REG_CYCLE_RATE:    rate_in      = csr_wdata;
            default: begin
               // index beyond the register list: ignored
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_OFF;
         notify_en_ff  <= 1'b0;
         min_ff        <= '0;
         max_ff        <= '1;
         rate_ff       <= '0;
         value_ff      <= '0;
         step_ff       <= '0;
         upd_period_ff <= '0;
         ticks_ff      <= '0;
         active_ff     <= 1'b1;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         mode_ff       <= mode_in;
         notify_en_ff  <= notify_en_in;
         min_ff        <= min_in;
         max_ff        <= max_in;
         rate_ff       <= rate_in;
         value_ff      <= value_in;
         step_ff       <= step_in;
         upd_period_ff <= upd_period_in;
         ticks_ff      <= ticks_in;
         active_ff     <= active_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      nv_ff        <= nv_in;
      prev_step_ff <= prev_step_in;
      period_ff    <= period_in;
      cnt_ff       <= cnt_in;
      upd_ff       <= upd_in;
      end_ff       <= end_in;
      rsp_data_ff  <= rsp_data_in;
   end

   assign req_ready = state_ff == ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------------------
   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      step_mag <= STEP_W'(STEP_LIMIT))
      else $error("step magnitude beyond search limit");

   a_div_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PERIOD || state_ff == ST_DELTA || state_ff == ST_RATIO)
      |-> (div_rsp.busy || div_rsp.done))
      else $error("waiting on divider that is not running");

   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_OUT))
      else $error("response raised outside output state");

   a_end_needs_update: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.value_updated)
      |-> (!rsp_data_ff.at_end && !rsp_data_ff.notify))
      else $error("end or notify flagged without a sweep update");

endmodule

`default_nettype wire
